// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL; they expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: always");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next cycle");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/ilir_pkg.sv =====
`timescale 1ns / 1ps

package ilir_pkg;

	localparam int ACTION_W = 3;
	localparam int POS_W    = 5;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_READ    = 3'd0,
		ACT_INSERT  = 3'd1,
		ACT_REMOVE  = 3'd2,
		ACT_APPEND  = 3'd3,
		ACT_DEQUEUE = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2
	} cell_op_t;

endpackage

// ===== rtl/core/ilir_cell.sv =====
`timescale 1ns / 1ps

module ilir_cell #(
	parameter int INDEX      = 0,
	parameter int IDX_W      = 4,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  ilir_pkg::cell_op_t    op,
	input  logic [IDX_W-1:0]      pos,
	input  logic [DATA_WIDTH-1:0] wr_value,
	input  logic [DATA_WIDTH-1:0] left_value,
	input  logic [DATA_WIDTH-1:0] right_value,
	output logic [DATA_WIDTH-1:0] value,
	output logic [DATA_WIDTH-1:0] sel_value
);
	import ilir_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [DATA_WIDTH-1:0] value_q;
	logic [DATA_WIDTH-1:0] value_d;

	always_comb begin
		value_d = value_q;
		case (op)
			CELL_INSERT: begin
				if (MY_IDX == pos) begin
					value_d = wr_value;
				end else if (MY_IDX > pos) begin
					value_d = left_value;
				end
			end
			CELL_REMOVE: begin
				if (MY_IDX >= pos) begin
					value_d = right_value;
				end
			end
			default: begin
				value_d = value_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value     = value_q;
	assign sel_value = (MY_IDX == pos) ? value_q : '0;

endmodule

// ===== rtl/core/indexed_list_insert_remove.sv =====
`timescale 1ns / 1ps

// An ordered list held in a row of cells, one entry per cell. An action word is taken on every
// clock edge at which start is high; busy never rises, so one word per cycle is sustained. An
// insert or remove moves every later entry by one place at once, each cell loading from its
// neighbour, so the action completes in the cycle it is taken. The result word appears in the cycle
// after acceptance with done high for exactly that cycle; it cannot be held off, so the receiver
// must capture it then. A failing action leaves the list untouched and reports its status.
module indexed_list_insert_remove #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ilir_pkg::ACTION_W-1:0]  action,
	input  logic [ilir_pkg::POS_W-1:0]     position,
	input  logic [ilir_pkg::VALUE_W-1:0]   entry_value,
	output logic                           done,
	output logic [ilir_pkg::VALUE_W-1:0]   result_value,
	output logic [ilir_pkg::COUNT_W-1:0]   entry_count,
	output logic [ilir_pkg::STATUS_W-1:0]  status
);
	import ilir_pkg::*;

	`include "assert_macros.svh"

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic                  done_q;
	logic [VALUE_W-1:0]    result_value_q;
	logic [COUNT_W-1:0]    entry_count_q;
	status_t               status_q;

	logic                  accept;
	cell_op_t              op_d;
	cell_op_t              cell_op;
	status_t               status_d;
	logic                  rd_en;
	logic [CMP_W-1:0]      eff_pos;
	logic [CMP_W-1:0]      pos_w;
	logic [CMP_W-1:0]      cnt_w;
	logic [CMP_W-1:0]      cnt_next_w;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [DATA_WIDTH-1:0] rd_data;
	logic [VALUE_W-1:0]    rd_word;

	logic [DATA_WIDTH-1:0] cell_value [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_sel   [CAPACITY];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign pos_w  = CMP_W'(position);
	assign cnt_w  = CMP_W'(count_q);

	generate
		if (DATA_WIDTH >= VALUE_W) begin : g_wide
			assign wr_data = DATA_WIDTH'(entry_value);
			assign rd_word = rd_data[VALUE_W-1:0];
		end else begin : g_narrow
			assign wr_data = entry_value[DATA_WIDTH-1:0];
			assign rd_word = VALUE_W'(rd_data);
		end
	endgenerate

	always_comb begin
		op_d     = CELL_HOLD;
		status_d = ST_OK;
		rd_en    = 1'b0;
		eff_pos  = '0;
		count_d  = count_q;
		case (action)
			ACT_READ: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else if (pos_w >= cnt_w) begin
					status_d = ST_RANGE;
				end else begin
					rd_en   = 1'b1;
					eff_pos = pos_w;
				end
			end
			ACT_INSERT: begin
				if (pos_w > cnt_w) begin
					status_d = ST_RANGE;
				end else if (cnt_w == CAP_C) begin
					status_d = ST_FULL;
				end else begin
					op_d    = CELL_INSERT;
					eff_pos = pos_w;
					count_d = count_q + CNT_W'(1);
				end
			end
			ACT_REMOVE: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else if (pos_w >= cnt_w) begin
					status_d = ST_RANGE;
				end else begin
					op_d    = CELL_REMOVE;
					rd_en   = 1'b1;
					eff_pos = pos_w;
					count_d = count_q - CNT_W'(1);
				end
			end
			ACT_APPEND: begin
				if (cnt_w == CAP_C) begin
					status_d = ST_FULL;
				end else begin
					op_d    = CELL_INSERT;
					eff_pos = cnt_w;
					count_d = count_q + CNT_W'(1);
				end
			end
			ACT_DEQUEUE: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					op_d    = CELL_REMOVE;
					rd_en   = 1'b1;
					eff_pos = '0;
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				op_d = CELL_HOLD;
			end
		endcase
	end

	assign cell_op    = accept ? op_d : CELL_HOLD;
	assign cnt_next_w = CMP_W'(count_d);

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [DATA_WIDTH-1:0] left_v;
			logic [DATA_WIDTH-1:0] right_v;
			if (i == 0) begin : g_first
				assign left_v = wr_data;
			end else begin : g_left
				assign left_v = cell_value[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_v = cell_value[i];
			end else begin : g_right
				assign right_v = cell_value[i+1];
			end
			ilir_cell #(
				.INDEX      (i),
				.IDX_W      (IDX_W),
				.DATA_WIDTH (DATA_WIDTH)
			) u_cell (
				.clk         (clk),
				.op          (cell_op),
				.pos         (eff_pos[IDX_W-1:0]),
				.wr_value    (wr_data),
				.left_value  (left_v),
				.right_value (right_v),
				.value       (cell_value[i]),
				.sel_value   (cell_sel[i])
			);
		end
	endgenerate

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | cell_sel[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_value_q <= rd_en ? rd_word : '0;
			entry_count_q  <= cnt_next_w[COUNT_W-1:0];
			status_q       <= status_d;
		end
	end

	assign done         = done_q;
	assign result_value = result_value_q;
	assign entry_count  = entry_count_q;
	assign status       = status_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, CMP_W'(count_q) <= CAP_C)
	`ASSERT_NEXT(a_done_follows, clk, arst_n, accept, done)
	`ASSERT_IMPLIES(a_full_count, clk, arst_n, done && (status_q == ST_FULL), CMP_W'(count_q) == CAP_C)
	`ASSERT_IMPLIES(a_fail_holds, clk, arst_n, done && (status_q != ST_OK), $stable(count_q))

endmodule
